@@ rtl/jbe_pkg.sv @@
// ----------------------------------------------------------------------------
// jbe_pkg: shared types and constants for the frame jitter bound estimator
// Holds the field widths, the min/max link carried along the cell chain,
// the control state type and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
package jbe_pkg;

    // field widths
    localparam int DUR_W = 31;
    localparam int DEF_W = 32;
    localparam int EST_W = 31;

    // signed width wide enough for negated deficits and bound differences
    localparam int BND_W = 34;

    // divisor applied to the minimum duration in the decaying bound
    localparam int DUR_DIVISOR = 13;

    // pipeline depth of the constant divider
    localparam int CDIV_LATENCY = 3;

    // smallest raw spread reported
    localparam logic [EST_W-1:0] SPREAD_FLOOR = 31'd17;

    // largest spread, also the saturation point
    localparam logic [EST_W-1:0] SPREAD_MAX = 31'h7FFF_FFFF;

    // identities for the running min/max entering the first cell
    localparam logic [DUR_W-1:0]        DUR_MIN_SEED = 31'h7FFF_FFFF;
    localparam logic [DUR_W-1:0]        DUR_MAX_SEED = 31'h0000_0000;
    localparam logic signed [DEF_W-1:0] DEF_MIN_SEED = 32'sh7FFF_FFFF;
    localparam logic signed [DEF_W-1:0] DEF_MAX_SEED = 32'sh8000_0000;

    // running extremes handed from one cell to the next
    typedef struct packed {
        logic [DUR_W-1:0]        dmin;
        logic [DUR_W-1:0]        dmax;
        logic signed [DEF_W-1:0] fmin;
        logic signed [DEF_W-1:0] fmax;
    } t_link;

    // control sequence of one item
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_COMB,
        S_FIN,
        S_PUSH
    } t_state;

endpackage

@@ rtl/jbe_cell.sv @@
// ----------------------------------------------------------------------------
// jbe_cell: one window slot of the estimator
// Stores one duration and one deficit entry and folds them into the
// running min/max that passes through, one cell per clock.
// ----------------------------------------------------------------------------
module jbe_cell
    import jbe_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [DUR_W-1:0]        i_dur,
    input  logic signed [DEF_W-1:0] i_def,
    input  t_link                   i_link,
    output t_link                   o_link
);

    logic [DUR_W-1:0]        r_dur;
    logic signed [DEF_W-1:0] r_def;
    t_link                   r_link;
    t_link                   n_link;

    // slot storage, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur <= '0;
            r_def <= '0;
        end else if (i_we) begin
            r_dur <= i_dur;
            r_def <= i_def;
        end
    end

    // fold this slot into the passing extremes
    always_comb begin
        n_link.dmin = (r_dur < i_link.dmin) ? r_dur : i_link.dmin;
        n_link.dmax = (r_dur > i_link.dmax) ? r_dur : i_link.dmax;
        n_link.fmin = (r_def < i_link.fmin) ? r_def : i_link.fmin;
        n_link.fmax = (r_def > i_link.fmax) ? r_def : i_link.fmax;
    end

    // hand the extremes to the next cell
    always_ff @(posedge i_clk) begin
        r_link <= n_link;
    end

    assign o_link = r_link;

endmodule

@@ rtl/jbe_cdiv.sv @@
// ----------------------------------------------------------------------------
// jbe_cdiv: divide by a constant
// Three-stage reciprocal multiply with one correction step; gives the
// floor quotient and whether the remainder is nonzero.
// ----------------------------------------------------------------------------
module jbe_cdiv
    import jbe_pkg::*;
#(
    parameter int DIVISOR = 13
)
(
    input  logic             i_clk,
    input  logic [DUR_W-1:0] i_num,
    output logic [DUR_W-1:0] o_quot,
    output logic             o_rem_nz
);

    localparam logic [63:0]      RECIP_W = (64'd1 << 32) / DIVISOR;
    localparam logic [31:0]      RECIP   = RECIP_W[31:0];
    localparam logic [DUR_W-1:0] DIV_V   = DUR_W'(DIVISOR);

    logic [62:0]      r_prod;
    logic [DUR_W-1:0] r_num1;
    logic [DUR_W-1:0] r_num2;
    logic [DUR_W-1:0] r_q0;
    logic [DUR_W-1:0] r_qd;
    logic [DUR_W-1:0] r_quot;
    logic             r_rem_nz;
    logic [DUR_W-1:0] w_q0;
    logic [DUR_W-1:0] w_diff;
    logic [DUR_W-1:0] n_quot;
    logic [DUR_W-1:0] n_rem;

    // stage 1: multiply by the scaled reciprocal
    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, i_num} * {31'd0, RECIP};
        r_num1 <= i_num;
    end

    // estimated quotient, at most one short of the true one
    assign w_q0 = r_prod[62:32];

    // stage 2: back-multiply the estimate
    always_ff @(posedge i_clk) begin
        r_q0   <= w_q0;
        r_qd   <= w_q0 * DIV_V;
        r_num2 <= r_num1;
    end

    // stage 3: single correction step
    always_comb begin
        w_diff = r_num2 - r_qd;
        if (w_diff >= DIV_V) begin
            n_quot = r_q0 + 1'b1;
            n_rem  = w_diff - DIV_V;
        end else begin
            n_quot = r_q0;
            n_rem  = w_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot   <= n_quot;
        r_rem_nz <= (n_rem != '0);
    end

    assign o_quot   = r_quot;
    assign o_rem_nz = r_rem_nz;

endmodule

@@ rtl/frame_jitter_bound_estimator.sv @@
// ----------------------------------------------------------------------------
// frame_jitter_bound_estimator: windowed frame jitter upper bound
// Keeps duration and deficit windows in a row of cells and combines their
// spreads with a decaying bound on the previous estimate.
// ----------------------------------------------------------------------------
// Usage
// - input stream: one frame sample per item (duration, deficit, cap);
//   the item is written into the window slot at the current write position
// - output stream: one jitter estimate per input item, in input order
// - the running min/max sweeps the chain of WINDOW_DEPTH cells one cell per
//   cycle, then two constant dividers (3 stages) run, then the combine and finish steps
// - an item passes the scan, divide, combine, finish and push states in order
// - a new item is taken only in the idle state, after the previous result has
//   left the push state for the output register
// - reset clears both windows, the write position and the stored estimate;
//   the first estimate decays from zero
// - a finished result waits in the output register; the next item is taken
//   meanwhile, and its result waits in the last step until the register frees
// - a stalled receiver holds o_m_axis_tvalid and the data steady
// ----------------------------------------------------------------------------
module frame_jitter_bound_estimator
    import jbe_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // frame_duration [30:0], timing_deficit [62:31], variance_cap [93:63]
    input  logic [95:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // jitter_estimate [30:0]
    output logic [31:0] o_m_axis_tdata
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = (SLOT_W > 2) ? SLOT_W : 2;
    localparam int DIV_A  = 5 * WINDOW_DEPTH + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  SCAN_END  = CNT_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  DIV_END   = CNT_W'(CDIV_LATENCY - 1);

    t_state                   r_state;
    t_state                   n_state;
    logic [SLOT_W-1:0]        r_slot;
    logic [CNT_W-1:0]         r_cnt;
    logic [EST_W-1:0]         r_est;
    logic [EST_W-1:0]         r_cap;
    logic [EST_W-1:0]         r_raw;
    logic signed [BND_W-1:0]  r_ba;
    logic signed [BND_W-1:0]  r_bb;
    logic signed [BND_W-1:0]  r_bc;
    logic                     r_out_valid;
    logic [EST_W-1:0]         r_out_data;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic                     w_cnt_clr;
    logic [DUR_W-1:0]         w_in_dur;
    logic signed [DEF_W-1:0]  w_in_def;
    t_link                    w_link [0:WINDOW_DEPTH];
    t_link                    w_tail;
    logic [DUR_W-1:0]         w_quot_a;
    logic                     w_nz_a;
    logic [DUR_W-1:0]         w_quot_b;
    logic                     w_nz_b;
    logic [DUR_W-1:0]         w_sspread;
    logic [DEF_W:0]           w_fdiff;
    logic [EST_W-1:0]         w_fspread;
    logic [EST_W-1:0]         n_raw;
    logic signed [BND_W-1:0]  w_fmax_x;
    logic signed [BND_W-1:0]  w_fmin_neg;
    logic signed [BND_W-1:0]  w_maxab;
    logic signed [BND_W-1:0]  w_lower;
    logic signed [BND_W-1:0]  w_up;
    logic signed [BND_W-1:0]  w_est;

    // input field unpacking
    assign w_in_dur = i_s_axis_tdata[30:0];
    assign w_in_def = i_s_axis_tdata[62:31];

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // chain of window cells
    assign w_link[0] = '{dmin: DUR_MIN_SEED, dmax: DUR_MAX_SEED,
                         fmin: DEF_MIN_SEED, fmax: DEF_MAX_SEED};

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        jbe_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (w_in_acc && (r_slot == SLOT_W'(g))),
            .i_dur   (w_in_dur),
            .i_def   (w_in_def),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    assign w_tail = w_link[WINDOW_DEPTH];

    // decay of the previous estimate by 5N/(5N+1)
    jbe_cdiv #(.DIVISOR(DIV_A)) u_div_est (
        .i_clk    (i_clk),
        .i_num    (r_est),
        .o_quot   (w_quot_a),
        .o_rem_nz (w_nz_a)
    );

    // minimum duration over 13
    jbe_cdiv #(.DIVISOR(DUR_DIVISOR)) u_div_dur (
        .i_clk    (i_clk),
        .i_num    (w_tail.dmin),
        .o_quot   (w_quot_b),
        .o_rem_nz (w_nz_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == SCAN_END) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_END) begin
                    n_state = S_COMB;
                end
            end
            S_COMB: n_state = S_FIN;
            S_FIN:  n_state = S_PUSH;
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_cnt_clr       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_cnt_clr       = 1'b1;
            end
            S_SCAN:  w_cnt_clr = (r_cnt == SCAN_END);
            S_DIV:   w_cnt_clr = (r_cnt == DIV_END);
            default: w_cnt_clr = 1'b1;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= w_cnt_clr ? '0 : r_cnt + 1'b1;
            if (w_in_acc) begin
                r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            end
        end
    end

    // cap travels with the item
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cap <= i_s_axis_tdata[93:63];
        end
    end

    // window spreads and bound terms
    always_comb begin
        w_sspread  = w_tail.dmax - w_tail.dmin;
        w_fdiff    = {w_tail.fmax[DEF_W-1], w_tail.fmax}
                   - {w_tail.fmin[DEF_W-1], w_tail.fmin};
        w_fspread  = (w_fdiff[DEF_W:EST_W] != '0) ? SPREAD_MAX : w_fdiff[EST_W-1:0];
        n_raw      = SPREAD_FLOOR;
        if (w_sspread > n_raw) begin
            n_raw = w_sspread;
        end
        if (w_fspread > n_raw) begin
            n_raw = w_fspread;
        end
        w_fmax_x   = BND_W'(w_tail.fmax);
        w_fmin_neg = -BND_W'(w_tail.fmin);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_COMB) begin
            r_raw <= n_raw;
            r_ba  <= signed'({3'b000, r_est}) - signed'({3'b000, w_quot_a})
                   - signed'({{(BND_W-1){1'b0}}, w_nz_a});
            r_bb  <= signed'({3'b000, r_est}) - signed'({3'b000, w_quot_b});
            r_bc  <= (w_fmax_x > w_fmin_neg) ? w_fmax_x : w_fmin_neg;
        end
    end

    // final combine
    always_comb begin
        w_maxab = (r_ba > r_bb) ? r_ba : r_bb;
        w_lower = (r_bc < w_maxab) ? r_bc : w_maxab;
        w_up    = (w_lower > signed'({3'b000, r_raw})) ? w_lower
                                                       : signed'({3'b000, r_raw});
        w_est   = (w_up < signed'({3'b000, r_cap})) ? w_up : signed'({3'b000, r_cap});
    end

    // stored estimate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
        end else if (r_state == S_FIN) begin
            r_est <= w_est[EST_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUSH && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && w_out_free) begin
            r_out_data <= r_est;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_data};

`ifndef NO_ASSERTIONS
    // an accepted item always starts a fresh sweep
    a_acc_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SCAN) && (r_cnt == '0))
        else $error("sweep did not start after accept");

    // the sweep never ends before the last cell has been reached
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && (r_cnt != SCAN_END) |=> (r_state == S_SCAN))
        else $error("sweep ended early");

    // the write position stays inside the window
    a_slot_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("write position out of range");

    // the delivered estimate is the one just stored
    a_push_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) && w_out_free
        |=> o_m_axis_tvalid && (o_m_axis_tdata[30:0] == r_est))
        else $error("delivered estimate differs from stored one");
`endif

endmodule

@@ tb/frame_jitter_bound_estimator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_jitter_bound_estimator_tb: self-checking bench for the jitter estimator
// Streams frame samples into the block and checks every estimate against a
// behavioral predictor that models both ring windows and the decaying bound.
// Runs a directed opening, then random phases under varied source idling and
// sink back-pressure, including a long sink hold-off and a full drain.
// ----------------------------------------------------------------------------
module frame_jitter_bound_estimator_tb;
    import jbe_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int RST_CYCLES  = 12;
    localparam int WIN         = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [DUR_W-1:0]        DUR_TOP = '1;
    localparam logic [EST_W-1:0]        CAP_TOP = '1;
    localparam logic signed [DEF_W-1:0] DEF_MOST = 32'sh7FFF_FFFF;
    localparam logic signed [DEF_W-1:0] DEF_LEAST = 32'sh8000_0000;

    // behavioral model of the estimator plus the queue of pending estimates
    class jitter_scoreboard;
        logic [DUR_W-1:0]        dur_ring[WIN];
        logic signed [DEF_W-1:0] def_ring[WIN];
        int unsigned             slot;
        longint                  estimate;
        logic [31:0]             pending_estimates[$];
        int                      failures;

        function new();
            for (int i = 0; i < WIN; i++) begin
                dur_ring[i] = '0;
                def_ring[i] = '0;
            end
            slot = 0;
            estimate = 0;
            failures = 0;
        endfunction

        // update the windows with one accepted item and queue its estimate
        function void note_sample(logic [95:0] item);
            logic [DUR_W-1:0]        dur;
            logic signed [DEF_W-1:0] def;
            logic [EST_W-1:0]        cap;
            longint dmin, dmax, fmin, fmax, raw, bnd_a, bnd_b, bnd_c, lower, nxt;
            dur = item[30:0];
            def = item[62:31];
            cap = item[93:63];
            dur_ring[slot] = dur;
            def_ring[slot] = def;
            slot = (slot + 1) % WIN;

            dmin = longint'({33'b0, dur_ring[0]});
            dmax = dmin;
            fmin = longint'(def_ring[0]);
            fmax = fmin;
            for (int i = 1; i < WIN; i++) begin
                if (longint'({33'b0, dur_ring[i]}) < dmin) dmin = longint'({33'b0, dur_ring[i]});
                if (longint'({33'b0, dur_ring[i]}) > dmax) dmax = longint'({33'b0, dur_ring[i]});
                if (longint'(def_ring[i]) < fmin) fmin = longint'(def_ring[i]);
                if (longint'(def_ring[i]) > fmax) fmax = longint'(def_ring[i]);
            end

            // widest spread with a floor, deficit spread saturating
            raw = 17;
            if (dmax - dmin > raw) raw = dmax - dmin;
            if (fmax - fmin > 64'sd2147483647) begin
                raw = 64'sd2147483647;
            end else if (fmax - fmin > raw) begin
                raw = fmax - fmin;
            end

            // decaying bound on the previous estimate, limited by deficit size
            bnd_a = (estimate * (5 * WIN)) / (5 * WIN + 1);
            bnd_b = estimate - dmin / 13;
            bnd_c = (fmax > -fmin) ? fmax : -fmin;
            lower = (bnd_a > bnd_b) ? bnd_a : bnd_b;
            if (bnd_c < lower) lower = bnd_c;

            nxt = (raw > lower) ? raw : lower;
            if (longint'({33'b0, cap}) < nxt) nxt = longint'({33'b0, cap});
            if (nxt < 0) nxt = 0;
            estimate = nxt;
            pending_estimates.push_back({1'b0, nxt[30:0]});
        endfunction

        function void check_estimate(logic [31:0] got);
            logic [31:0] want;
            if (pending_estimates.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected estimate item 0x%08h", $time, got);
                return;
            end
            want = pending_estimates.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: jitter_estimate mismatch, expected %0d actual %0d",
                             $time, want, got);
            end
        endfunction

        function int pending();
            return pending_estimates.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [95:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;

    jitter_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int nominal_dur = 279620;

    frame_jitter_bound_estimator #(
        .WINDOW_DEPTH(WIN)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // sink ready: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            sb.check_estimate(o_m_axis_tdata);
    end

    // pad bits above the cap are random, the block must ignore them
    function automatic logic [95:0] pack_sample(logic [DUR_W-1:0] dur,
                                                logic signed [DEF_W-1:0] def,
                                                logic [EST_W-1:0] cap);
        logic [1:0] pad;
        pad = 2'($urandom_range(3));
        return {pad, cap, def, dur};
    endfunction

    // random frame sample drawn from a mix of realistic and hostile regimes
    function automatic logic [95:0] make_sample();
        int                      pick;
        logic [DUR_W-1:0]        dur;
        logic signed [DEF_W-1:0] def;
        logic [EST_W-1:0]        cap;
        pick = $urandom_range(99);
        dur = DUR_W'(nominal_dur + $urandom_range(4000) - 2000);
        def = $signed($urandom_range(8000)) - 4000;
        cap = ($urandom_range(9) == 0) ? EST_W'($urandom) : CAP_TOP;
        if (pick < 45) begin
            // steady frames, estimate decays
        end else if (pick < 60) begin
            def = $signed($urandom_range(2000000)) - 1000000;
        end else if (pick < 75) begin
            dur = DUR_W'($urandom);
            def = $urandom;
            cap = EST_W'($urandom);
        end else if (pick < 85) begin
            cap = EST_W'($urandom_range(100));
        end else if (pick < 93) begin
            dur = $urandom_range(1) ? DUR_TOP : '0;
            case ($urandom_range(3))
                0: def = DEF_MOST;
                1: def = DEF_LEAST;
                2: def = '0;
                default: def = -1;
            endcase
        end else begin
            dur = DUR_W'(nominal_dur + $urandom_range(nominal_dur));
        end
        return pack_sample(dur, def, cap);
    endfunction

    task automatic send_sample(logic [95:0] item);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_sample(item);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit with_hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        nominal_dur    = $urandom_range(2000000, 1000);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (with_hold && i == 40) hold_requests++;
            send_sample(make_sample());
        end
        drain();
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: floor, extremes, saturation, zero cap, decay path
        send_sample(pack_sample('0, '0, CAP_TOP));
        send_sample(pack_sample(DUR_TOP, DEF_MOST, CAP_TOP));
        send_sample(pack_sample('0, DEF_LEAST, CAP_TOP));
        send_sample(pack_sample(DUR_TOP, DEF_LEAST, '0));
        send_sample(pack_sample(DUR_TOP, DEF_MOST, '0));
        send_sample(pack_sample(31'd5, -1, CAP_TOP));
        send_sample(pack_sample(31'd7, 32'sd1, 31'd10));
        send_sample(pack_sample('0, DEF_MOST, 31'h5555_5555));
        send_sample(pack_sample(31'h2AAA_AAAA, 32'sh5555_5555, 31'h2AAA_AAAA));
        send_sample({2'b11, 94'b0});
        for (int i = 0; i < 10; i++)
            send_sample(pack_sample(DUR_W'(31'd279620 + i * 3), 32'sd500 - i * 90,
                                    CAP_TOP));
        for (int i = 0; i < 4; i++)
            send_sample(pack_sample(31'd279620, 32'sd20, CAP_TOP));
        drain();

        run_phase(0, 0, 1'b1);
        run_phase(80, 0, 1'b0);
        run_phase(0, 80, 1'b0);
        run_phase(19, 19, 1'b0);

        repeat (WIN + 20) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
